// ===== sv/lbds_pkg.sv =====
`default_nettype none
package lbds_pkg;

   localparam int COUNT_BITS_DEFAULT  = 20;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int POINT_W             = 20;
   localparam int CAM_W               = 24;
   localparam int COEF_W              = 16;
   localparam int CSR_W               = 64;
   localparam int CSR_IDX_W           = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Z      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTRINSICS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BBOX       = 3'd4;

   typedef struct packed {
      logic signed [CAM_W-1:0] x;
      logic signed [CAM_W-1:0] y;
      logic signed [CAM_W-1:0] z;
      logic                    last;
   } cam_point_type;

   function automatic logic [COEF_W-1:0] lane(input logic [CSR_W-1:0] word, input int idx);
      return word[COEF_W*idx +: COEF_W];
   endfunction

endpackage
`default_nettype wire

// ===== sv/lbds_front.sv =====
`default_nettype none
module lbds_front
   import lbds_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [POINT_W-1:0]            req_point_x,
   input  wire logic signed [POINT_W-1:0]            req_point_y,
   input  wire logic signed [POINT_W-1:0]            req_point_z,
   input  wire logic                                 req_last,
   input  wire logic [CSR_W-1:0]                     row_x,
   input  wire logic [CSR_W-1:0]                     row_y,
   input  wire logic [CSR_W-1:0]                     row_z,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]     queue_level,
   output logic                                      push,
   output cam_point_type                             push_data
);

   localparam int LEVEL_W = $clog2(QUEUE_DEPTH+1);
   localparam int PROD_W  = COEF_W + POINT_W;
   localparam int ACC_W   = PROD_W + 2;

   logic [CSR_W-1:0]             rows [3];
   logic signed [POINT_W-1:0]    pts [3];
   logic signed [PROD_W-1:0]     prod_ff [3][3];
   logic signed [COEF_W-1:0]     ofs_ff [3];
   logic                         last_ff;
   logic                         valid_ff;
   logic                         accept;
   logic signed [ACC_W-1:0]      acc [3];
   logic signed [ACC_W-1:0]      shifted [3];
   logic signed [CAM_W-1:0]      sat [3];

   assign rows[0] = row_x;
   assign rows[1] = row_y;
   assign rows[2] = row_z;
   assign pts[0]  = req_point_x;
   assign pts[1]  = req_point_y;
   assign pts[2]  = req_point_z;

   // An item in the product stage still needs a queue slot.
   assign req_stall = (LEVEL_W+1)'(queue_level) + (LEVEL_W+1)'(valid_ff)
                      >= (LEVEL_W+1)'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      if (accept) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= $signed(lane(rows[r], c)) * pts[c];
            end
            ofs_ff[r] <= $signed(lane(rows[r], 3));
         end
         last_ff <= req_last;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = ACC_W'(prod_ff[r][0]) + ACC_W'(prod_ff[r][1]) + ACC_W'(prod_ff[r][2])
                  + (ACC_W'(ofs_ff[r]) <<< 8);
         shifted[r] = acc[r] >>> 11;
         if (shifted[r] > ACC_W'(8388607)) begin
            sat[r] = 24'sh7FFFFF;
         end else if (shifted[r] < -ACC_W'(8388608)) begin
            sat[r] = 24'sh800000;
         end else begin
            sat[r] = CAM_W'(shifted[r]);
         end
      end
   end

   assign push           = valid_ff;
   assign push_data.x    = sat[0];
   assign push_data.y    = sat[1];
   assign push_data.z    = sat[2];
   assign push_data.last = last_ff;

endmodule
`default_nettype wire

// ===== sv/lbds_queue.sv =====
`default_nettype none
module lbds_queue
   import lbds_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   input  wire cam_point_type                    push_data,
   input  wire logic                             pop,
   output cam_point_type                         head,
   output logic                                  not_empty,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]      level
);

   localparam int LEVEL_W = $clog2(QUEUE_DEPTH+1);
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);

   cam_point_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [LEVEL_W-1:0]   level_ff;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH-1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (push && !pop) begin
            level_ff <= level_ff + LEVEL_W'(1);
         end else if (pop && !push) begin
            level_ff <= level_ff - LEVEL_W'(1);
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = level_ff != '0;
   assign level     = level_ff;

endmodule
`default_nettype wire

// ===== sv/lbds_back.sv =====
`default_nettype none
module lbds_back
   import lbds_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [CSR_W-1:0]     intrinsics,
   input  wire logic [CSR_W-1:0]     bbox_window,
   input  wire cam_point_type        head,
   input  wire logic                 not_empty,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [20:0]               rsp_point_count,
   output logic [22:0]               rsp_avg_depth,
   output logic [22:0]               rsp_max_depth,
   output logic                      rsp_has_points
);

   localparam int CNT_W  = COUNT_BITS + 1;
   localparam int SUM_W  = COUNT_BITS + 24;
   localparam int DCNT_W = $clog2(SUM_W + 1);
   localparam int PU_W   = COEF_W + 1 + CAM_W;
   localparam int PB_W   = COEF_W + CAM_W;
   localparam int CMP_W  = PU_W + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CMP  = 3'd1;
   localparam logic [2:0] ST_ACC  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(1) << COUNT_BITS;

   logic [2:0]                state_ff;
   logic signed [PU_W-1:0]    fxx_ff, oxz_ff, fyy_ff, oyz_ff;
   logic signed [PB_W-1:0]    xmin_ff, xmax_ff, ymin_ff, ymax_ff;
   logic signed [CAM_W-1:0]   z_ff;
   logic                      last_ff;
   logic                      inside_ff;
   logic signed [CMP_W-1:0]   un, vn;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [22:0]               peak_ff, peak_in;
   logic [SUM_W-1:0]          quo_ff;
   logic [CNT_W-1:0]          rem_ff;
   logic [CNT_W-1:0]          div_count_ff;
   logic [22:0]               div_peak_ff;
   logic [DCNT_W-1:0]         steps_ff;
   logic [CNT_W:0]            trial;
   logic                      fits;
   logic                      load_rsp;

   assign pop = (state_ff == ST_IDLE) && not_empty;

   assign un = CMP_W'(fxx_ff) + CMP_W'(oxz_ff);
   assign vn = CMP_W'(fyy_ff) + CMP_W'(oyz_ff);

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      peak_in  = peak_ff;
      if (inside_ff) begin
         if (count_ff < COUNT_LIMIT) begin
            count_in = count_ff + CNT_W'(1);
            sum_in   = sum_ff + SUM_W'(z_ff[22:0]);
         end
         if (z_ff[22:0] > peak_ff) begin
            peak_in = z_ff[22:0];
         end
      end
   end

   assign trial    = {rem_ff, quo_ff[SUM_W-1]};
   assign fits     = trial >= {1'b0, div_count_ff};
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sum_ff    <= '0;
         count_ff  <= '0;
         peak_ff   <= '0;
         rsp_valid <= 1'b0;
      end else begin
         if (load_rsp) begin
            rsp_valid <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (not_empty) begin
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (last_ff) begin
                  sum_ff   <= '0;
                  count_ff <= '0;
                  peak_ff  <= '0;
                  state_ff <= ST_DIV;
               end else begin
                  sum_ff   <= sum_in;
                  count_ff <= count_in;
                  peak_ff  <= peak_in;
                  state_ff <= ST_IDLE;
               end
            end
            ST_DIV: begin
               if (steps_ff == DCNT_W'(1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (load_rsp) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         fxx_ff  <= $signed({1'b0, lane(intrinsics, 0)}) * head.x;
         fyy_ff  <= $signed({1'b0, lane(intrinsics, 1)}) * head.y;
         oxz_ff  <= $signed({1'b0, lane(intrinsics, 2)}) * head.z;
         oyz_ff  <= $signed({1'b0, lane(intrinsics, 3)}) * head.z;
         xmin_ff <= $signed(lane(bbox_window, 0)) * head.z;
         ymin_ff <= $signed(lane(bbox_window, 1)) * head.z;
         xmax_ff <= $signed(lane(bbox_window, 2)) * head.z;
         ymax_ff <= $signed(lane(bbox_window, 3)) * head.z;
         z_ff    <= head.z;
         last_ff <= head.last;
      end
      if (state_ff == ST_CMP) begin
         inside_ff <= (z_ff > 0)
                      && (un >= CMP_W'(xmin_ff)) && (un <= CMP_W'(xmax_ff))
                      && (vn >= CMP_W'(ymin_ff)) && (vn <= CMP_W'(ymax_ff));
      end
      if (state_ff == ST_ACC && last_ff) begin
         quo_ff       <= sum_in;
         rem_ff       <= '0;
         div_count_ff <= count_in;
         div_peak_ff  <= peak_in;
         steps_ff     <= DCNT_W'(SUM_W);
      end
      if (state_ff == ST_DIV) begin
         rem_ff   <= fits ? CNT_W'(trial - {1'b0, div_count_ff}) : CNT_W'(trial);
         quo_ff   <= {quo_ff[SUM_W-2:0], fits};
         steps_ff <= steps_ff - DCNT_W'(1);
      end
      if (load_rsp) begin
         rsp_point_count <= 21'(div_count_ff);
         rsp_avg_depth   <= (div_count_ff == '0) ? '0 : quo_ff[22:0];
         rsp_max_depth   <= div_peak_ff;
         rsp_has_points  <= div_count_ff != '0;
      end
   end

endmodule
`default_nettype wire

// ===== sv/lidar_bbox_depth_stats_unit.sv =====
// Depth statistics of lidar points that project into a pixel box.
// Input channel req_*: one lidar point per item, req_last closes a scan.
// Result channel rsp_*: one report per scan, carried by the item with last set.
// Configuration is written through csr_wr_en, csr_index and csr_wdata; the user
// must write it only while idle; the block itself does not enforce this.
// The front part applies the rigid transform through a registered product stage
// and places the camera point in a small queue; the back part takes each point
// in three steps (product, compare, accumulate) before it pops the next one.
// The mean depth comes from a one-bit-per-cycle divider of COUNT_BITS + 24
// steps. The front keeps taking items while the back works or a report waits,
// as long as the queue has room.
// Reset clears the configuration registers, the queue and the accumulators, and
// rsp_valid drops. When the receiver stalls, the report is held unchanged and
// the back part goes on with the following points until the next report is
// ready; then it waits, the queue fills and req_stall rises.
`default_nettype none
module lidar_bbox_depth_stats_unit
   import lbds_pkg::*;
#(
   parameter int COUNT_BITS  = COUNT_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_W-1:0]           csr_wdata,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic signed [POINT_W-1:0]  req_point_x,
   input  wire logic signed [POINT_W-1:0]  req_point_y,
   input  wire logic signed [POINT_W-1:0]  req_point_z,
   input  wire logic                       req_last,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [20:0]                     rsp_point_count,
   output logic [22:0]                     rsp_avg_depth,
   output logic [22:0]                     rsp_max_depth,
   output logic                            rsp_has_points
);

   logic [CSR_W-1:0]                     row_x_ff, row_y_ff, row_z_ff;
   logic [CSR_W-1:0]                     intrinsics_ff, bbox_ff;
   logic                                 push, pop, not_empty;
   cam_point_type                        push_data, head;
   logic [$clog2(QUEUE_DEPTH+1)-1:0]     level;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff      <= '0;
         row_y_ff      <= '0;
         row_z_ff      <= '0;
         intrinsics_ff <= '0;
         bbox_ff       <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_X:      row_x_ff      <= csr_wdata;
            CSR_ROW_Y:      row_y_ff      <= csr_wdata;
            CSR_ROW_Z:      row_z_ff      <= csr_wdata;
            CSR_INTRINSICS: intrinsics_ff <= csr_wdata;
            CSR_BBOX:       bbox_ff       <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   lbds_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock, .reset, .req_valid, .req_stall,
      .req_point_x, .req_point_y, .req_point_z, .req_last,
      .row_x(row_x_ff), .row_y(row_y_ff), .row_z(row_z_ff),
      .queue_level(level), .push, .push_data
   );

   lbds_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset, .push, .push_data, .pop, .head, .not_empty, .level
   );

   lbds_back #(.COUNT_BITS(COUNT_BITS)) u_back (
      .clock, .reset, .intrinsics(intrinsics_ff), .bbox_window(bbox_ff),
      .head, .not_empty, .pop, .rsp_valid, .rsp_stall,
      .rsp_point_count, .rsp_avg_depth, .rsp_max_depth, .rsp_has_points
   );

endmodule
`default_nettype wire

// ===== sv/lbds_checker.sv =====
`default_nettype none
module lbds_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [20:0] rsp_point_count,
   input wire logic [22:0] rsp_avg_depth,
   input wire logic [22:0] rsp_max_depth,
   input wire logic        rsp_has_points
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_count)
         && $stable(rsp_avg_depth) && $stable(rsp_max_depth) && $stable(rsp_has_points))
      else $error("report changed while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("report valid after reset");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_points |-> rsp_point_count == 21'd0
         && rsp_avg_depth == 23'd0 && rsp_max_depth == 23'd0)
      else $error("empty scan report not zero");

   a_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_points |-> rsp_avg_depth <= rsp_max_depth
         && rsp_max_depth != 23'd0)
      else $error("mean depth above peak depth");

endmodule

bind lidar_bbox_depth_stats_unit lbds_checker u_lbds_checker (.*);
`default_nettype wire
